>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge of clk, off while rst is high.
`define ASSERT_AT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Expression that must never be true at a rising edge of clk.
`define ASSERT_NEVER_AT_CLK(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

>>> hw/rtl/tfe_pkg.sv
// Package of the tile enumerator: widths, register indexes, sequencer types.
`default_nettype none
package tfe_pkg;

  localparam int MAX_LOG2_BINS = 10;

  localparam int LOG2_W   = 4;
  localparam int BIN_W    = 10;
  localparam int CURSOR_W = 11;
  localparam int SIZE_W   = 12;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] CFG_LOG2_BINS      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_TIME_BINS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_FREQ_BINS  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OVERLAP_FACTOR = 2'd3;

  // restoring divider: one quotient bit per cycle
  localparam int DIV_STEPS = SIZE_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETTLE,
    ST_DIV,
    ST_APPLY,
    ST_EMIT
  } state_t;

  typedef enum logic [2:0] {
    ACT_DONE,
    ACT_EXHAUST,
    ACT_NEXT_PLANE,
    ACT_STEP_DUR,
    ACT_STEP_TIME,
    ACT_STEP_WIDTH
  } act_t;

  typedef enum logic [1:0] {
    TGT_DUR,
    TGT_TIME,
    TGT_WIDTH,
    TGT_FREQ
  } tgt_t;

  typedef struct packed {
    logic [LOG2_W-1:0] plane_index;
    logic [BIN_W-1:0]  time_first;
    logic [BIN_W-1:0]  time_last;
    logic [BIN_W-1:0]  freq_first;
    logic [BIN_W-1:0]  freq_last;
    logic              last_tile;
    logic              none_left;
  } tile_t;

endpackage
`default_nettype wire

>>> hw/rtl/tfe_if.sv
// Handshake interfaces: tile request channel and tile result channel.
`default_nettype none
interface tfe_req_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface tfe_tile_if;
  import tfe_pkg::*;
  logic              valid;
  logic              ready;
  logic [LOG2_W-1:0] plane_index;
  logic [BIN_W-1:0]  time_first;
  logic [BIN_W-1:0]  time_last;
  logic [BIN_W-1:0]  freq_first;
  logic [BIN_W-1:0]  freq_last;
  logic              last_tile;
  logic              none_left;

  modport source (output valid, output plane_index, output time_first, output time_last,
                  output freq_first, output freq_last, output last_tile, output none_left,
                  input ready);
  modport sink   (input valid, input plane_index, input time_first, input time_last,
                  input freq_first, input freq_last, input last_tile, input none_left,
                  output ready);
endinterface
`default_nettype wire

>>> hw/rtl/tf_tile_enumerator.sv
// Time-frequency tile enumerator: sequencer around one shared divider.
//
//  channel  dir  beat payload
//  req      in   restart
//  tile     out  plane_index, time/freq first+last, last_tile, none_left
//  cfg      in   cfg_write, cfg_index, cfg_data (write only, no stall)
//
// A request runs the nested search in ST_SETTLE. Each divided cursor step (the freq
// step after each tile, plus each step past an empty level) goes through the
// divider in ST_DIV and is added in ST_APPLY; a plane change, or the search running out, is settled in ST_SETTLE.
// Each such step runs through the bit-serial divider by overlap_factor.
// req.ready is high only while the sequencer is idle; a finished tile sits in
// the output register, so the next request is taken while it waits.
// rst is synchronous; cursors come back at the first tile of the search.
`default_nettype none
`include "assert_macros.svh"
module tf_tile_enumerator (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_write,
  input  wire logic [tfe_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [tfe_pkg::CFG_DATA_W-1:0]  cfg_data,
  tfe_req_if.sink                              req,
  tfe_tile_if.source                           tile
);
  import tfe_pkg::*;

  // configuration
  logic [LOG2_W-1:0]     log2_bins;
  logic [BIN_W-1:0]      min_time_bins;
  logic [BIN_W-1:0]      min_freq_bins;
  logic [BIN_W-1:0]      overlap_factor;

  // cursors
  logic [LOG2_W-1:0]     plane_counter;
  logic [SIZE_W-1:0]     duration_cursor;
  logic [CURSOR_W-1:0]   time_cursor;
  logic [SIZE_W-1:0]     width_cursor;
  logic [CURSOR_W-1:0]   freq_cursor;
  logic                  exhausted;

  // sequencer
  state_t                state, state_next;
  act_t                  act;
  tgt_t                  tgt;
  logic                  post;

  // divider
  logic [BIN_W-1:0]      div_rem;
  logic [SIZE_W-1:0]     div_quo;
  logic [DIV_CNT_W-1:0]  div_cnt;
  logic [BIN_W:0]        div_trial;
  logic                  div_ge;

  tile_t                 pend;
  tile_t                 out_reg;
  logic                  out_valid;

  logic                  in_beat;
  logic                  out_free;
  logic [LOG2_W-1:0]     lg_eff;
  logic [CURSOR_W-1:0]   tb;
  logic [CURSOR_W-1:0]   fb;
  logic [SIZE_W-1:0]     min_t_eff;
  logic [SIZE_W-1:0]     min_f_eff;
  logic [BIN_W-1:0]      ov_eff;
  logic [SIZE_W-1:0]     time_end;
  logic [SIZE_W-1:0]     freq_end;
  logic [SIZE_W-1:0]     stride;

  assign in_beat   = req.valid && req.ready;
  assign out_free  = !out_valid || tile.ready;

  assign lg_eff    = (log2_bins > LOG2_W'(MAX_LOG2_BINS)) ? LOG2_W'(MAX_LOG2_BINS) : log2_bins;
  assign tb        = CURSOR_W'(1) << plane_counter;
  assign fb        = (CURSOR_W'(1) << lg_eff) >> plane_counter;
  assign min_t_eff = (min_time_bins == '0) ? SIZE_W'(1) : SIZE_W'(min_time_bins);
  assign min_f_eff = (min_freq_bins == '0) ? SIZE_W'(1) : SIZE_W'(min_freq_bins);
  assign ov_eff    = (overlap_factor == '0) ? BIN_W'(1) : overlap_factor;

  // start + size past the extent means start > extent - size
  assign time_end  = SIZE_W'(time_cursor) + duration_cursor;
  assign freq_end  = SIZE_W'(freq_cursor) + width_cursor;

  assign div_trial = {div_rem, div_quo[SIZE_W-1]};
  assign div_ge    = div_trial >= {1'b0, ov_eff};
  assign stride    = div_quo + SIZE_W'(1);

  // one level of the nested search per cycle in ST_SETTLE
  always_comb begin
    if (exhausted) begin
      act = ACT_DONE;
    end else if (plane_counter > lg_eff) begin
      act = ACT_EXHAUST;
    end else if (duration_cursor > SIZE_W'(tb)) begin
      act = ACT_NEXT_PLANE;
    end else if (time_end > SIZE_W'(tb)) begin
      act = ACT_STEP_DUR;
    end else if (width_cursor > SIZE_W'(fb)) begin
      act = ACT_STEP_TIME;
    end else if (freq_end > SIZE_W'(fb)) begin
      act = ACT_STEP_WIDTH;
    end else begin
      act = ACT_DONE;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_beat) state_next = ST_SETTLE;
      end
      ST_SETTLE: begin
        case (act)
          ACT_DONE:                                   state_next = (post || exhausted) ? ST_EMIT
                                                                                       : ST_DIV;
          ACT_STEP_DUR, ACT_STEP_TIME, ACT_STEP_WIDTH: state_next = ST_DIV;
          default:                                    state_next = ST_SETTLE;
        endcase
      end
      ST_DIV: begin
        if (div_cnt == DIV_CNT_W'(DIV_STEPS - 1)) state_next = ST_APPLY;
      end
      ST_APPLY: state_next = ST_SETTLE;
      ST_EMIT: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req.ready        = (state == ST_IDLE);
    tile.valid       = out_valid;
    tile.plane_index = out_reg.plane_index;
    tile.time_first  = out_reg.time_first;
    tile.time_last   = out_reg.time_last;
    tile.freq_first  = out_reg.freq_first;
    tile.freq_last   = out_reg.freq_last;
    tile.last_tile   = out_reg.last_tile;
    tile.none_left   = out_reg.none_left;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      log2_bins       <= LOG2_W'(MAX_LOG2_BINS);
      min_time_bins   <= BIN_W'(1);
      min_freq_bins   <= BIN_W'(1);
      overlap_factor  <= BIN_W'(2);
      plane_counter   <= '0;
      duration_cursor <= SIZE_W'(1);
      time_cursor     <= '0;
      width_cursor    <= SIZE_W'(1);
      freq_cursor     <= '0;
      exhausted       <= 1'b0;
      post            <= 1'b0;
      tgt             <= TGT_DUR;
      div_cnt         <= '0;
      out_valid       <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_write) begin
        case (cfg_index)
          CFG_LOG2_BINS:      log2_bins      <= cfg_data[LOG2_W-1:0];
          CFG_MIN_TIME_BINS:  min_time_bins  <= cfg_data[BIN_W-1:0];
          CFG_MIN_FREQ_BINS:  min_freq_bins  <= cfg_data[BIN_W-1:0];
          CFG_OVERLAP_FACTOR: overlap_factor <= cfg_data[BIN_W-1:0];
          default: ;
        endcase
      end

      if (state == ST_EMIT && out_free) begin
        out_valid <= 1'b1;
      end else if (tile.valid && tile.ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          post <= 1'b0;
          if (in_beat && req.restart) begin
            plane_counter   <= '0;
            duration_cursor <= min_t_eff;
            time_cursor     <= '0;
            width_cursor    <= min_f_eff;
            freq_cursor     <= '0;
            exhausted       <= 1'b0;
          end
        end
        ST_SETTLE: begin
          div_cnt <= '0;
          div_rem <= '0;
          case (act)
            ACT_EXHAUST: exhausted <= 1'b1;
            ACT_NEXT_PLANE: begin
              plane_counter   <= plane_counter + LOG2_W'(1);
              duration_cursor <= min_t_eff;
              time_cursor     <= '0;
              width_cursor    <= min_f_eff;
              freq_cursor     <= '0;
            end
            ACT_STEP_DUR: begin
              tgt     <= TGT_DUR;
              div_quo <= duration_cursor;
            end
            ACT_STEP_TIME: begin
              tgt     <= TGT_TIME;
              div_quo <= duration_cursor;
            end
            ACT_STEP_WIDTH: begin
              tgt     <= TGT_WIDTH;
              div_quo <= width_cursor;
            end
            default: begin
              if (post) begin
                pend.last_tile <= exhausted;
              end else if (exhausted) begin
                pend <= '{none_left: 1'b1, default: '0};
              end else begin
                pend.plane_index <= plane_counter;
                pend.time_first  <= time_cursor[BIN_W-1:0];
                pend.time_last   <= time_end[BIN_W-1:0] - BIN_W'(1);
                pend.freq_first  <= freq_cursor[BIN_W-1:0];
                pend.freq_last   <= freq_end[BIN_W-1:0] - BIN_W'(1);
                pend.last_tile   <= 1'b0;
                pend.none_left   <= 1'b0;
                post             <= 1'b1;
                tgt              <= TGT_FREQ;
                div_quo          <= width_cursor;
              end
            end
          endcase
        end
        ST_DIV: begin
          div_rem <= div_ge ? BIN_W'(div_trial - {1'b0, ov_eff}) : div_trial[BIN_W-1:0];
          div_quo <= {div_quo[SIZE_W-2:0], div_ge};
          div_cnt <= div_cnt + DIV_CNT_W'(1);
        end
        ST_APPLY: begin
          case (tgt)
            TGT_DUR: begin
              duration_cursor <= duration_cursor + stride;
              time_cursor     <= '0;
              width_cursor    <= min_f_eff;
              freq_cursor     <= '0;
            end
            TGT_TIME: begin
              time_cursor  <= time_cursor + stride[CURSOR_W-1:0];
              width_cursor <= min_f_eff;
              freq_cursor  <= '0;
            end
            TGT_WIDTH: begin
              width_cursor <= width_cursor + stride;
              freq_cursor  <= '0;
            end
            default: freq_cursor <= freq_cursor + stride[CURSOR_W-1:0];
          endcase
        end
        ST_EMIT: begin
          if (out_free) begin
            out_reg <= pend;
          end
        end
        default: ;
      endcase
    end
  end

  `ASSERT_AT_CLK(a_div_cnt_range, (state == ST_DIV) |-> (div_cnt <= DIV_CNT_W'(DIV_STEPS - 1)), "divider count out of range")
  `ASSERT_AT_CLK(a_busy_after_req, in_beat |=> !req.ready, "request taken while busy")
  `ASSERT_AT_CLK(a_none_left_clean, (tile.valid && tile.none_left) |-> (!tile.last_tile && tile.plane_index == '0 && tile.time_last == '0 && tile.freq_last == '0), "none_left beat carries data")
  `ASSERT_NEVER_AT_CLK(a_plane_bound, plane_counter > LOG2_W'(MAX_LOG2_BINS + 1), "plane counter past last plane")

endmodule
`default_nettype wire
